[src/bspd_pkg.sv]
`default_nettype none

package bspd_pkg;

  localparam int unsigned DelayW = 31;

  typedef logic [1:0]        op_t;
  typedef logic [7:0]        char_t;
  typedef logic [DelayW-1:0] delay_t;
  typedef logic [2:0]        phase_t;
  typedef logic [1:0]        opr_t;

  localparam op_t OP_CHAR  = 2'd0;
  localparam op_t OP_RETRY = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_DELAY   = 1'b1;

  localparam phase_t PH_START  = 3'd0;
  localparam phase_t PH_STEP   = 3'd1;
  localparam phase_t PH_LIMIT  = 3'd2;
  localparam phase_t PH_TAIL   = 3'd3;
  localparam phase_t PH_REJECT = 3'd4;

  localparam opr_t OPR_NONE = 2'd0;
  localparam opr_t OPR_ADD  = 2'd1;
  localparam opr_t OPR_MUL  = 2'd2;

  localparam char_t CH_TERM  = 8'h00;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_STAR  = 8'h2A;
  localparam char_t CH_LESS  = 8'h3C;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  localparam delay_t SAT_MAX       = {DelayW{1'b1}};
  localparam delay_t DEFAULT_LIMIT = 31'd86400;

endpackage

`default_nettype wire

[src/bspd_in_if.sv]
`default_nettype none

interface bspd_in_if import bspd_pkg::*;
();
  logic  valid;
  logic  ready;
  op_t   op;
  char_t char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

`default_nettype wire

[src/bspd_out_if.sv]
`default_nettype none

interface bspd_out_if import bspd_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   kind;
  logic   parse_ok;
  delay_t delay_value;

  modport source (output valid, output kind, output parse_ok, output delay_value,
                  input ready);
  modport sink   (input valid, input kind, input parse_ok, input delay_value,
                  output ready);
endinterface

`default_nettype wire

[src/backoff_spec_parser_delay_core.sv]
`default_nettype none

// Channel   Direction  Payload                          Transfers
// in_i      sink       op[1:0], char_code[7:0]          0 or 1 per cycle
// out_o     source     kind, parse_ok, delay_value[30:0] 0 or 1 per cycle
//
// One item per cycle is sustained while the output is not stalled; an item is held
// in the input register and its result is then registered in the output register.
// The longest path is the 31 x 31 retry multiply followed by saturate and clamp.
// Reset returns the parser, the held spec and the current delay to their
// defaults. A stalled output holds its result while an item still waits in
// the input register; characters that give no result drain regardless.

module backoff_spec_parser_delay_core import bspd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bspd_in_if.sink     in_i,
  bspd_out_if.source  out_o
);

  logic   s1_valid_q;
  op_t    s1_op_q;
  char_t  s1_char_q;

  phase_t phase_q, phase_d;
  delay_t work_start_q, work_start_d;
  opr_t   work_opr_q, work_opr_d;
  delay_t work_step_q, work_step_d;
  delay_t work_limit_q, work_limit_d;
  delay_t held_start_q, held_start_d;
  opr_t   held_opr_q, held_opr_d;
  delay_t held_step_q, held_step_d;
  delay_t held_limit_q, held_limit_d;
  logic   held_valid_q, held_valid_d;
  delay_t delay_q, delay_d;

  logic   out_valid_q;
  logic   out_kind_q, out_kind_d;
  logic   out_ok_q, out_ok_d;
  delay_t out_delay_q, out_delay_d;

  logic   produces;
  logic   out_free;
  logic   s1_fire;
  logic   is_digit;
  logic [3:0] digit;
  delay_t acc_sel;
  logic [DelayW+3:0] acc_x10;
  delay_t acc_next;
  logic [DelayW:0] sum;
  logic [2*DelayW-1:0] prod;
  delay_t adv;
  delay_t clamped;
  logic   verdict_ok;

  assign produces = ((s1_op_q == OP_CHAR) && (s1_char_q == CH_TERM)) ||
                    (s1_op_q == OP_RETRY) || (s1_op_q == OP_CLEAR);
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && (!produces || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_op_q   <= in_i.op;
      s1_char_q <= in_i.char_code;
    end
  end

  assign is_digit = (s1_char_q >= CH_ZERO) && (s1_char_q <= CH_NINE);
  assign digit    = 4'(s1_char_q - CH_ZERO);

  always_comb begin
    case (phase_q)
      PH_START: acc_sel = work_start_q;
      PH_STEP:  acc_sel = work_step_q;
      default:  acc_sel = work_limit_q;
    endcase
  end

  assign acc_x10  = ({4'd0, acc_sel} << 3) + ({4'd0, acc_sel} << 1) +
                    {{DelayW{1'b0}}, digit};
  assign acc_next = (|acc_x10[DelayW+3:DelayW]) ? SAT_MAX : acc_x10[DelayW-1:0];

  assign sum  = {1'b0, delay_q} + {1'b0, held_step_q};
  assign prod = {{DelayW{1'b0}}, delay_q} * {{DelayW{1'b0}}, held_step_q};

  always_comb begin
    if (delay_q == '0) begin
      adv = held_start_q;
    end else begin
      case (held_opr_q)
        OPR_ADD: adv = sum[DelayW] ? SAT_MAX : sum[DelayW-1:0];
        OPR_MUL: adv = (|prod[2*DelayW-1:DelayW]) ? SAT_MAX : prod[DelayW-1:0];
        default: adv = delay_q;
      endcase
    end
  end

  assign clamped = (adv > held_limit_q) ? held_limit_q : adv;

  always_comb begin
    case (phase_q)
      PH_START, PH_STEP: verdict_ok = 1'b1;
      PH_LIMIT, PH_TAIL: verdict_ok = (work_limit_q != '0);
      default:           verdict_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    work_start_d = work_start_q;
    work_opr_d   = work_opr_q;
    work_step_d  = work_step_q;
    work_limit_d = work_limit_q;
    held_start_d = held_start_q;
    held_opr_d   = held_opr_q;
    held_step_d  = held_step_q;
    held_limit_d = held_limit_q;
    held_valid_d = held_valid_q;
    delay_d      = delay_q;
    out_kind_d   = KIND_DELAY;
    out_ok_d     = held_valid_q;
    out_delay_d  = delay_q;

    if (s1_fire) begin
      case (s1_op_q)
        OP_CHAR: begin
          if (s1_char_q == CH_TERM) begin
            held_start_d = work_start_q;
            held_opr_d   = work_opr_q;
            held_step_d  = work_step_q;
            held_limit_d = work_limit_q;
            held_valid_d = verdict_ok;
            phase_d      = PH_START;
            work_start_d = '0;
            work_opr_d   = OPR_NONE;
            work_step_d  = '0;
            work_limit_d = DEFAULT_LIMIT;
            out_kind_d   = KIND_VERDICT;
            out_ok_d     = verdict_ok;
            out_delay_d  = delay_q;
          end else begin
            case (phase_q)
              PH_START: begin
                if (is_digit) begin
                  work_start_d = acc_next;
                end else if (s1_char_q == CH_PLUS) begin
                  work_opr_d = OPR_ADD;
                  phase_d    = PH_STEP;
                end else if (s1_char_q == CH_STAR) begin
                  work_opr_d = OPR_MUL;
                  phase_d    = PH_STEP;
                end else begin
                  phase_d = PH_REJECT;
                end
              end
              PH_STEP: begin
                if (is_digit) begin
                  work_step_d = acc_next;
                end else if (s1_char_q == CH_LESS) begin
                  work_limit_d = '0;
                  phase_d      = PH_LIMIT;
                end else begin
                  phase_d = PH_REJECT;
                end
              end
              PH_LIMIT: begin
                if (is_digit) begin
                  work_limit_d = acc_next;
                end else begin
                  phase_d = PH_TAIL;
                end
              end
              PH_TAIL: begin
                phase_d = PH_TAIL;
              end
              default: begin
                phase_d = PH_REJECT;
              end
            endcase
          end
        end
        OP_RETRY: begin
          delay_d     = held_valid_q ? clamped : '0;
          out_delay_d = delay_d;
        end
        OP_CLEAR: begin
          delay_d     = '0;
          out_delay_d = '0;
        end
        default: begin
          delay_d = delay_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      work_start_q <= '0;
      work_opr_q   <= OPR_NONE;
      work_step_q  <= '0;
      work_limit_q <= DEFAULT_LIMIT;
      held_start_q <= '0;
      held_opr_q   <= OPR_NONE;
      held_step_q  <= '0;
      held_limit_q <= DEFAULT_LIMIT;
      held_valid_q <= 1'b0;
      delay_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      work_start_q <= work_start_d;
      work_opr_q   <= work_opr_d;
      work_step_q  <= work_step_d;
      work_limit_q <= work_limit_d;
      held_start_q <= held_start_d;
      held_opr_q   <= held_opr_d;
      held_step_q  <= held_step_d;
      held_limit_q <= held_limit_d;
      held_valid_q <= held_valid_d;
      delay_q      <= delay_d;
      if (s1_fire && produces) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && produces) begin
      out_kind_q  <= out_kind_d;
      out_ok_q    <= out_ok_d;
      out_delay_q <= out_delay_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.parse_ok    = out_ok_q;
  assign out_o.delay_value = out_delay_q;

  // A retry under a valid spec never leaves the delay above the held limit.
  a_retry_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_op_q == OP_RETRY) && held_valid_q) |=> (delay_q <= held_limit_q))
    else $error("delay exceeds limit after retry");

  // A retry under an invalid spec, or a clear, leaves the delay at zero.
  a_delay_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && ((s1_op_q == OP_CLEAR) || ((s1_op_q == OP_RETRY) && !held_valid_q)))
    |=> (delay_q == '0))
    else $error("delay not zeroed");

  // The parser never leaves its five phases.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q <= PH_REJECT))
    else $error("parser phase out of range");

  // A result transfer that the sink stalls keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_delay_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
